@@ sv/assert_macros.svh @@
// Assertion macros used by the core module of the debounce press counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BDPC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a state invariant holds on every rising clock edge outside of reset.
`define BDPC_ASSERT_INV(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

@@ sv/bdpc_pkg.sv @@
// Package with types and constants of the button debounce press counter.
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

  // Debounce run length and press counter limit.
  localparam int unsigned DEBOUNCE_COUNT = 3;
  localparam int unsigned MAX_PRESSES    = 7;

  // Field widths.
  localparam int unsigned AMOUNT_W = 8;
  localparam int unsigned PRESS_W  = 3;
  localparam int unsigned RUN_W    = $clog2(DEBOUNCE_COUNT + 1);

  localparam int unsigned PRESS_FIELD_MAX = (1 << PRESS_W) - 1;
  localparam int unsigned PRESS_LIMIT_INT =
      (MAX_PRESSES > PRESS_FIELD_MAX) ? PRESS_FIELD_MAX : MAX_PRESSES;

  localparam logic [RUN_W-1:0]   DEBOUNCE_V  = RUN_W'(DEBOUNCE_COUNT);
  localparam logic [PRESS_W-1:0] PRESS_LIMIT = PRESS_W'(PRESS_LIMIT_INT);

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned S_FIELDS_W = 2 + AMOUNT_W;
  localparam int unsigned M_FIELDS_W = 2 + PRESS_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Request kinds.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_DECREASE = 1'b1;

  typedef struct packed {
    logic                op;
    logic                pin_level;
    logic [AMOUNT_W-1:0] decrease_amount;
  } bdpc_item_t;

  typedef struct packed {
    logic               button_down;
    logic [PRESS_W-1:0] press_count;
    logic               brightness_step;
  } bdpc_result_t;

endpackage

`default_nettype wire

@@ sv/bdpc_in_stage.sv @@
// Input register that holds one accepted request until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module bdpc_in_stage import bdpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire bdpc_item_t item_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output bdpc_item_t      item_o
);

  logic       valid_q, valid_d;
  bdpc_item_t item_q;
  logic       load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ sv/bdpc_core.sv @@
// Debounce state, press counter and the update logic for one request.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bdpc_core import bdpc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       take_i,
  input  wire bdpc_item_t item_i,
  output bdpc_result_t    result_o
);

  logic               count_mode_q;
  logic [RUN_W-1:0]   cnt_rel_q, cnt_rel_d;
  logic [RUN_W-1:0]   cnt_prs_q, cnt_prs_d;
  logic               deb_q, deb_d;
  logic [PRESS_W-1:0] pend_q, pend_d;
  logic               step;
  logic               pressed;
  logic [RUN_W-1:0]   own_cnt;
  logic [RUN_W-1:0]   own_inc;

  assign pressed = !item_i.pin_level;
  assign own_cnt = pressed ? cnt_prs_q : cnt_rel_q;
  assign own_inc = own_cnt + RUN_W'(1);

  always_comb begin
    cnt_rel_d = cnt_rel_q;
    cnt_prs_d = cnt_prs_q;
    deb_d     = deb_q;
    pend_d    = pend_q;
    step      = 1'b0;
    case (item_i.op)
      OP_TICK: begin
        // A sample of one level breaks the run of the other level.
        if (pressed) begin
          cnt_rel_d = '0;
        end else begin
          cnt_prs_d = '0;
        end
        if (own_cnt < DEBOUNCE_V) begin
          if (pressed) begin
            cnt_prs_d = own_inc;
          end else begin
            cnt_rel_d = own_inc;
          end
          if (own_inc == DEBOUNCE_V) begin
            deb_d = pressed;
            if (!deb_q && pressed) begin
              if (count_mode_q) begin
                if (pend_q < PRESS_LIMIT) begin
                  pend_d = pend_q + PRESS_W'(1);
                end
              end else begin
                step = 1'b1;
              end
            end
          end
        end
      end
      OP_DECREASE: begin
        if (item_i.decrease_amount <= {{(AMOUNT_W-PRESS_W){1'b0}}, pend_q}) begin
          pend_d = pend_q - item_i.decrease_amount[PRESS_W-1:0];
        end else begin
          pend_d = '0;
        end
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q <= 1'b0;
      cnt_rel_q    <= '0;
      cnt_prs_q    <= '0;
      deb_q        <= 1'b0;
      pend_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        count_mode_q <= cfg_wdata_i;
      end
      if (take_i) begin
        cnt_rel_q <= cnt_rel_d;
        cnt_prs_q <= cnt_prs_d;
        deb_q     <= deb_d;
        pend_q    <= pend_d;
      end
    end
  end

  assign result_o.button_down     = deb_d;
  assign result_o.press_count     = pend_d;
  assign result_o.brightness_step = step;

  // At most one of the two run counters is nonzero.
  `BDPC_ASSERT_INV(a_runs_exclusive, !(cnt_rel_q != '0 && cnt_prs_q != '0), "both runs active")
  // The press counter never passes its limit.
  `BDPC_ASSERT_INV(a_press_limit, pend_q <= PRESS_LIMIT, "press count above limit")
  // A brightness step only happens outside user mode, on a released-to-pressed change.
  `BDPC_ASSERT_RST(a_step_cause, (take_i && step) |-> (!count_mode_q && !deb_q && deb_d), "bad step")
  // A decrease request leaves the debounced state alone.
  `BDPC_ASSERT_RST(a_dec_keeps_state, (take_i && item_i.op == OP_DECREASE) |=> deb_q == $past(deb_q), "state moved")

endmodule

`default_nettype wire

@@ sv/bdpc_out_stage.sv @@
// Result register that holds one result until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module bdpc_out_stage import bdpc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire bdpc_result_t result_i,
  input  wire logic         ready_i,
  output logic              valid_o,
  output logic              free_o,
  output bdpc_result_t      result_o
);

  logic         valid_q, valid_d;
  bdpc_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ sv/button_debounce_press_counter_top.sv @@
// Top level of the button debounce press counter.
//
// Each request on the slave stream carries either one sample of an active-low
// button pin (a tick) or a decrease of the press counter. Every request gives
// exactly one result on the master stream: the debounced button state, the
// press counter and a one-result brightness step pulse.
// A request is taken into an input register, passes one short update of the
// debounce counters and the press counter, and lands in a result register.
// The result is registered in the result register after the input register, and
// while the receiver takes each result a new request can be accepted on every clock,
// so the sustained rate is one request per cycle. The single update of the
// state registers per request is what sets that rate.
// When the receiver stalls, the result register holds its result and the input
// register still takes one more request; after that s_axis_tready_o drops
// until the receiver drains the result. Reset clears both run counters, the
// debounced state (released), the press counter, the user mode register and
// both valid flags. cfg_we_i writes the user mode bit; the user must write it
// only while no request is in flight, and the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_counter_top import bdpc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,       // count mode bit
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // op [0], pin_level [1], decrease_amount [9:2], zero padding above
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // button_down [0], press_count [3:1], brightness_step [4], zero padding above
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o
);

  bdpc_item_t   s_item;
  bdpc_item_t   held_item;
  bdpc_result_t core_result;
  bdpc_result_t out_result;
  logic         held_valid;
  logic         out_free;
  logic         take;

  // Unpack the request fields from the lowest bit up.
  assign s_item.op              = s_axis_tdata_i[0];
  assign s_item.pin_level       = s_axis_tdata_i[1];
  assign s_item.decrease_amount = s_axis_tdata_i[AMOUNT_W+1:2];

  // The held request moves on whenever the result register can take its result.
  assign take = held_valid && out_free;

  bdpc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (s_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  bdpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (held_item),
    .result_o    (core_result)
  );

  bdpc_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .result_i (core_result),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .free_o   (out_free),
    .result_o (out_result)
  );

  // Pack the result fields from the lowest bit up, zeros above.
  assign m_axis_tdata_o = {{(M_TDATA_W-M_FIELDS_W){1'b0}},
                           out_result.brightness_step,
                           out_result.press_count,
                           out_result.button_down};

endmodule

`default_nettype wire

@@ dv/button_debounce_press_counter_top_test.sv @@
// Self-checking stream testbench for the button debounce press counter top level.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_counter_top_test;
  import bdpc_pkg::*;

  // Run-time bounds. The slowest correct run is set by the sender gap, the
  // receiver stall and the latency of each request, plus one long hold-off,
  // so the cycle limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned NUM_PHASES   = 8;

  // Kinds of rows in the directed table.
  typedef enum logic {
    ROW_REQUEST,
    ROW_WRITE_MODE
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    bdpc_item_t   item;
    logic         mode_value;
    logic         has_typed;
    bdpc_result_t typed;
  } directed_row_t;

  // Block interface.
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 s_valid;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_data;
  logic                 m_axis_tvalid_o;
  logic                 m_ready;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  button_debounce_press_counter_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Predictor state: run lengths of pressed and released samples, the
  // debounced level, the pending press counter and the user mode bit.
  logic [RUN_W-1:0]   pressed_run;
  logic [RUN_W-1:0]   released_run;
  logic               debounced_down;
  logic [PRESS_W-1:0] pending_presses;
  logic               count_mode;

  // Button status results still owed by the block, oldest first.
  bdpc_result_t awaited_status[$];
  directed_row_t directed_rows[$];

  // Hand-off from the stimulus process to the monitor: a typed expectation
  // replaces the predicted one for the request that is being offered.
  logic         typed_pending;
  bdpc_result_t typed_status;

  int  fail_count;
  int  cycle_count;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  rx_hold_armed;

  // Clock with a 12 ns period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advances the debounce and press counter state by one request and returns
  // the status the block should report for it.
  function automatic bdpc_result_t next_button_status(input bdpc_item_t item);
    bdpc_result_t status;
    status.brightness_step = 1'b0;
    if (item.op == OP_TICK) begin
      if (!item.pin_level) begin
        // Pressed sample: the released run starts over.
        released_run = '0;
        if (pressed_run < DEBOUNCE_V) begin
          pressed_run = pressed_run + 1'b1;
          if (pressed_run == DEBOUNCE_V) begin
            // Only a released-to-pressed change counts as a press.
            if (!debounced_down) begin
              if (count_mode) begin
                if (pending_presses < PRESS_LIMIT) pending_presses = pending_presses + 1'b1;
              end else begin
                status.brightness_step = 1'b1;
              end
            end
            debounced_down = 1'b1;
          end
        end
      end else begin
        pressed_run = '0;
        if (released_run < DEBOUNCE_V) begin
          released_run = released_run + 1'b1;
          if (released_run == DEBOUNCE_V) debounced_down = 1'b0;
        end
      end
    end else begin
      // Decrease floors at zero; the pin sample plays no part.
      if (int'(item.decrease_amount) <= int'(pending_presses)) begin
        pending_presses = pending_presses - item.decrease_amount[PRESS_W-1:0];
      end else begin
        pending_presses = '0;
      end
    end
    status.button_down = debounced_down;
    status.press_count = pending_presses;
    return status;
  endfunction

  // Cycle counter with the run time limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. An accepted
  // request queues its expected status; an accepted result is checked
  // against the oldest queued status.
  always @(posedge clk_i) begin
    bdpc_item_t   req;
    bdpc_result_t predicted;
    bdpc_result_t exp;
    bdpc_result_t act;
    if (rst_ni && s_valid && s_axis_tready_o) begin
      req.op              = s_data[0];
      req.pin_level       = s_data[1];
      req.decrease_amount = s_data[9:2];
      predicted = next_button_status(req);
      awaited_status.push_back(typed_pending ? typed_status : predicted);
    end
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      act.button_down     = m_axis_tdata_o[0];
      act.press_count     = m_axis_tdata_o[3:1];
      act.brightness_step = m_axis_tdata_o[4];
      if (awaited_status.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        exp = awaited_status.pop_front();
        if (act.button_down !== exp.button_down) begin
          $error("button_down: expected %0d, actual %0d", exp.button_down, act.button_down);
          fail_count++;
        end
        if (act.press_count !== exp.press_count) begin
          $error("press_count: expected %0d, actual %0d", exp.press_count, act.press_count);
          fail_count++;
        end
        if (act.brightness_step !== exp.brightness_step) begin
          $error("brightness_step: expected %0d, actual %0d",
                 exp.brightness_step, act.brightness_step);
          fail_count++;
        end
      end
    end
  end

  // Receiver: when idling is on, before each result it waits a random number
  // of cycles with tready low. When a hold-off is armed it stays low much longer,
  // counted here, so the block fills up and drops s_axis_tready_o.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (rx_hold_armed) begin
        rx_hold_armed = 1'b0;
        stall += HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Offers one request, after a random gap when idling is on, and returns at the falling edge
  // that follows its acceptance, with tvalid still high.
  task automatic send_request(input bdpc_item_t item);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, item.decrease_amount, item.pin_level, item.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Stops offering and waits at falling edges until every status is back.
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (awaited_status.size() != 0);
  endtask

  // Writes the mode register while nothing is in flight.
  task automatic write_count_mode(input logic value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    count_mode = value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic bdpc_item_t tick_item(input logic pin);
    bdpc_item_t item;
    item.op              = OP_TICK;
    item.pin_level       = pin;
    item.decrease_amount = 8'($urandom_range(0, 255));
    return item;
  endfunction

  function automatic bdpc_item_t decrease_item(input logic [AMOUNT_W-1:0] amount);
    bdpc_item_t item;
    item.op              = OP_DECREASE;
    item.pin_level       = 1'($urandom_range(0, 1));
    item.decrease_amount = amount;
    return item;
  endfunction

  // Directed table helpers: one call per row.
  function automatic void add_request(input logic op, input logic pin,
                                      input logic [AMOUNT_W-1:0] amount,
                                      input logic has_typed, input logic down,
                                      input logic [PRESS_W-1:0] count, input logic bright);
    directed_row_t row;
    row.kind                  = ROW_REQUEST;
    row.item.op               = op;
    row.item.pin_level        = pin;
    row.item.decrease_amount  = amount;
    row.mode_value            = 1'b0;
    row.has_typed             = has_typed;
    row.typed.button_down     = down;
    row.typed.press_count     = count;
    row.typed.brightness_step = bright;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_mode_write(input logic value);
    directed_row_t row;
    row.kind       = ROW_WRITE_MODE;
    row.item       = '0;
    row.mode_value = value;
    row.has_typed  = 1'b0;
    row.typed      = '0;
    directed_rows.push_back(row);
  endfunction

  // One random phase. Most of it is well-formed press and release runs long
  // enough to pass the debounce; the rest is single bouncing samples and
  // decreases, mostly small so the counter sits near its ends.
  task automatic run_random_phase(input int phase);
    int          sent;
    int unsigned pick;
    int unsigned run_len;
    int unsigned dec_pct;
    logic [AMOUNT_W-1:0] amount;
    bit          paused;
    bit          held;
    sent    = 0;
    paused  = 1'b0;
    held    = 1'b0;
    dec_pct = phase[0] ? 25 : 5;
    while (sent < PHASE_ITEMS) begin
      // Sender pause until every result is back.
      if (phase == 6 && sent >= 60 && !paused) begin
        drain_results();
        paused = 1'b1;
      end
      // Long receiver hold-off while requests keep coming.
      if (phase == 4 && sent >= 40 && !held) begin
        rx_hold_armed = 1'b1;
        held          = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < dec_pct) begin
        case ($urandom_range(0, 3))
          0, 1:    amount = 8'($urandom_range(0, 3));
          2:       amount = 8'($urandom_range(4, 8));
          default: amount = 8'($urandom_range(0, 255));
        endcase
        send_request(decrease_item(amount));
        sent++;
      end else if (pick < dec_pct + 12) begin
        send_request(tick_item(1'($urandom_range(0, 1))));
        sent++;
      end else begin
        run_len = $urandom_range(DEBOUNCE_COUNT, DEBOUNCE_COUNT + 3);
        repeat (run_len) send_request(tick_item(1'b0));
        sent += run_len;
        run_len = $urandom_range(DEBOUNCE_COUNT, DEBOUNCE_COUNT + 3);
        repeat (run_len) send_request(tick_item(1'b1));
        sent += run_len;
      end
    end
  endtask

  // Main stimulus: reset, directed table, random phases, end of run.
  initial begin
    logic phase_mode[NUM_PHASES];
    phase_mode      = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    s_valid         = 1'b0;
    s_data          = '0;
    m_ready         = 1'b0;
    rst_ni          = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    typed_pending   = 1'b0;
    typed_status    = '0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rx_hold_armed   = 1'b0;
    pressed_run     = '0;
    released_run    = '0;
    debounced_down  = 1'b0;
    pending_presses = '0;
    count_mode      = 1'b0;

    // Directed table. Typed expectations only where the answer is obvious;
    // the other rows go through the predictor.
    // Brightness mode after reset: decreases on an empty counter, including
    // the largest amount, leave everything at zero.
    add_request(OP_DECREASE, 1'b1, 8'd0,   1'b1, 1'b0, 3'd0, 1'b0);
    add_request(OP_DECREASE, 1'b0, 8'd255, 1'b1, 1'b0, 3'd0, 1'b0);
    // Three pressed samples debounce into a press and one brightness pulse.
    add_request(OP_TICK,     1'b0, 8'd255, 1'b1, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b1, 1'b1, 3'd0, 1'b1);
    // A held level changes nothing and gives no second pulse.
    add_request(OP_TICK,     1'b0, 8'd0,   1'b1, 1'b1, 3'd0, 1'b0);
    // A bounce to released and back, then a clean release.
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    // User mode: two presses are counted.
    add_mode_write(1'b1);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    // Leaving user mode keeps the count; a decrease past it floors at zero.
    add_mode_write(1'b0);
    add_request(OP_DECREASE, 1'b0, 8'd1,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_DECREASE, 1'b1, 8'd255, 1'b1, 1'b1, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);
    add_request(OP_TICK,     1'b1, 8'd0,   1'b0, 1'b0, 3'd0, 1'b0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE_MODE) begin
        write_count_mode(directed_rows[i].mode_value);
      end else begin
        typed_pending = directed_rows[i].has_typed;
        typed_status  = directed_rows[i].typed;
        send_request(directed_rows[i].item);
      end
    end
    typed_pending = 1'b0;

    // Random phases set the mode from phase_mode. Some phases run without idling on
    // one side or both so back-to-back transfers are exercised too.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_count_mode(phase_mode[phase]);
      tx_idle_on = !(phase == 2 || phase == 5);
      rx_idle_on = !(phase == 3 || phase == 5);
      run_random_phase(phase);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/bdpc_pkg.sv
sv/bdpc_in_stage.sv
sv/bdpc_core.sv
sv/bdpc_out_stage.sv
sv/button_debounce_press_counter_top.sv
dv/button_debounce_press_counter_top_test.sv
